// ===== rtl/pip_pkg.sv =====
// shared types, constants and register codes for the point-in-polygon test
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 4;
  localparam int COORD_W = 32;
  localparam int EPS_W   = 16;
  localparam int NODE_W  = 3;
  localparam int CFG_W   = 16;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 3'd4;
  localparam logic [EPS_W-1:0]  EDGE_EPS_RST   = 16'd1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic {
    REG_NODE_COUNT   = 1'b0,
    REG_EDGE_EPSILON = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] xmin;
    logic signed [COORD_W-1:0] xmax;
    logic signed [COORD_W-1:0] ymin;
    logic signed [COORD_W-1:0] ymax;
  } bbox_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W+1:0] rx;
    logic signed [COORD_W+2:0] vx;
    logic        [EPS_W-1:0]   eps;
    logic                      vx_pos;
  } calc_t;

endpackage

// ===== rtl/pip_cell.sv =====
// one vertex cell: holds a vertex, extends the bounding box, tests its edge, adds to the count
module pip_cell
  import pip_pkg::*;
#(
  parameter bit IS_FIRST = 1'b0,
  parameter int CW = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic signed [COORD_W-1:0] wx,
  input  logic signed [COORD_W-1:0] wy,
  input  logic                      active,
  input  logic signed [COORD_W-1:0] nbr_x,
  input  logic signed [COORD_W-1:0] nbr_y,
  input  bbox_t                     bbox_in,
  input  calc_t                     calc,
  input  logic        [CW-1:0]      cnt_in,
  output logic signed [COORD_W-1:0] own_x,
  output logic signed [COORD_W-1:0] own_y,
  output bbox_t                     bbox_out,
  output logic        [CW-1:0]      cnt_out
);

  logic signed [COORD_W-1:0] vx_reg, vy_reg;
  logic signed [32:0] dx, dy, dp, den_c, num_c;
  logic signed [34:0] xr_c;
  logic signed [32:0] s1_num, s1_den, s1_uix;
  logic signed [34:0] s1_xr;
  logic               s1_horiz, s1_lt, s1_neg;
  logic signed [67:0] p1, lim;
  logic signed [65:0] p2;
  logic signed [49:0] ed;
  logic signed [16:0] eps_s;
  logic signed [67:0] s2_p1, s2_lim;
  logic signed [65:0] s2_p2;
  logic signed [49:0] s2_ed;
  logic signed [32:0] s2_num;
  logic               s2_horiz, s2_lt, s2_neg;
  logic signed [49:0] mu_sum;
  logic signed [68:0] t;
  logic               mu_ok, hit;
  bbox_t              bbox_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx_reg <= '0;
      vy_reg <= '0;
    end else if (we) begin
      vx_reg <= wx;
      vy_reg <= wy;
    end
  end

  assign own_x = vx_reg;
  assign own_y = vy_reg;

  // bounding box chain
  always_comb begin
    bbox_next = bbox_in;
    if (IS_FIRST) begin
      bbox_next.xmin = vx_reg;
      bbox_next.xmax = vx_reg;
      bbox_next.ymin = vy_reg;
      bbox_next.ymax = vy_reg;
    end else if (active) begin
      if (vx_reg < $signed(bbox_in.xmin)) bbox_next.xmin = vx_reg;
      if (vx_reg > $signed(bbox_in.xmax)) bbox_next.xmax = vx_reg;
      if (vy_reg < $signed(bbox_in.ymin)) bbox_next.ymin = vy_reg;
      if (vy_reg > $signed(bbox_in.ymax)) bbox_next.ymax = vy_reg;
    end
  end

  always_ff @(posedge clk) begin
    bbox_out <= bbox_next;
  end

  // edge stage 1: differences and sign normalization
  always_comb begin
    dx    = {nbr_x[COORD_W-1], nbr_x} - {vx_reg[COORD_W-1], vx_reg};
    dy    = {nbr_y[COORD_W-1], nbr_y} - {vy_reg[COORD_W-1], vy_reg};
    dp    = {calc.py[COORD_W-1], calc.py} - {vy_reg[COORD_W-1], vy_reg};
    den_c = dy[32] ? -dy : dy;
    num_c = dy[32] ? -dp : dp;
    xr_c  = {{3{vx_reg[COORD_W-1]}}, vx_reg} - {calc.rx[COORD_W+1], calc.rx};
  end

  always_ff @(posedge clk) begin
    s1_num   <= num_c;
    s1_den   <= den_c;
    s1_uix   <= dx;
    s1_xr    <= xr_c;
    s1_horiz <= (dy == '0);
    s1_lt    <= (num_c < den_c);
    s1_neg   <= num_c[32];
  end

  // edge stage 2: products
  assign eps_s = $signed({1'b0, calc.eps});
  assign p1    = s1_xr * s1_den;
  assign p2    = s1_num * s1_uix;
  assign lim   = s1_den * calc.vx;
  assign ed    = eps_s * s1_den;

  always_ff @(posedge clk) begin
    s2_p1    <= p1;
    s2_p2    <= p2;
    s2_lim   <= lim;
    s2_ed    <= ed;
    s2_num   <= s1_num;
    s2_horiz <= s1_horiz;
    s2_lt    <= s1_lt;
    s2_neg   <= s1_neg;
  end

  // edge stage 3: crossing decision
  assign mu_sum = $signed({s2_num, 16'b0}) + s2_ed;
  assign mu_ok  = s2_lt && (!s2_neg || (mu_sum > 50'sd0));
  assign t      = s2_p1 + s2_p2;

  always_ff @(posedge clk) begin
    hit <= active && calc.vx_pos && !s2_horiz && mu_ok && (t > 69'sd0) && (t < s2_lim);
  end

  // count chain
  always_ff @(posedge clk) begin
    cnt_out <= cnt_in + CW'(hit);
  end

endmodule

// ===== rtl/polygon_point_inside_test_core.sv =====
// Point-in-polygon test on a row of vertex cells. Load requests write a
// vertex each. A query request runs from acceptance to a registered
// result: the bounding box ripples through the registers of the cell row,
// each cell's edge test runs three stages, and the crossing count ripples
// through the row from the first cell to the last.
// One query is in flight at a time; a new request is taken while the last
// result still waits at the output.
module polygon_point_inside_test_core
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic        [1:0]         vertex_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      inside_res,
  output logic                      in_box,
  output logic        [2:0]         crossing_count,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic        [CFG_W-1:0]   cfg_data
);

  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int LAT = 2 * MAX_VERTICES + 4;
  localparam int TW  = $clog2(LAT + 1);

  logic [NODE_W-1:0] node_count;
  logic [EPS_W-1:0]  edge_epsilon;
  state_t            state, state_next;
  logic [TW-1:0]     timer;
  logic              accept, load_req, query_req, out_load;
  logic signed [COORD_W-1:0] px, py;
  logic [4:0]        n5, n_eff;
  calc_t             calc;
  logic              box_ok;

  logic signed [COORD_W-1:0] own_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] own_y [MAX_VERTICES];
  bbox_t                     bbox  [MAX_VERTICES];
  logic [CW-1:0]             cnt   [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= NODE_COUNT_RST;
      edge_epsilon <= EDGE_EPS_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NODE_COUNT:   node_count   <= cfg_data[NODE_W-1:0];
        REG_EDGE_EPSILON: edge_epsilon <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign n5 = {2'b0, node_count};
  always_comb begin
    n_eff = n5;
    if (n5 < 5'd3) n_eff = 5'd3;
    if (n5 > 5'(MAX_VERTICES)) n_eff = 5'(MAX_VERTICES);
  end

  assign accept    = in_valid && in_ready;
  assign load_req  = accept && (mode == MODE_LOAD);
  assign query_req = accept && (mode == MODE_QUERY);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (query_req) state_next = ST_BUSY;
      ST_BUSY: if (timer == TW'(LAT - 1)) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_BUSY: ;
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      timer <= '0;
    end else begin
      state <= state_next;
      if (state == ST_BUSY) timer <= timer + TW'(1);
      else                  timer <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (query_req) begin
      px <= coord_x;
      py <= coord_y;
    end
  end

  // common terms from the finished bounding box
  logic signed [COORD_W+1:0] xm34, rx_c;
  logic signed [COORD_W+2:0] vx_c;
  bbox_t bb;
  always_comb begin
    bb   = bbox[MAX_VERTICES-1];
    xm34 = {{2{bb.xmin[COORD_W-1]}}, bb.xmin};
    rx_c = bb.xmin[COORD_W-1] ? (xm34 + (xm34 <<< 1)) : -xm34;
    vx_c = {{3{px[COORD_W-1]}}, px} - {rx_c[COORD_W+1], rx_c};
  end

  always_ff @(posedge clk) begin
    calc.py     <= py;
    calc.rx     <= rx_c;
    calc.vx     <= vx_c;
    calc.eps    <= edge_epsilon;
    calc.vx_pos <= (vx_c > '0);
    box_ok      <= !(px > $signed(bb.xmax) || px < $signed(bb.xmin) ||
                     py > $signed(bb.ymax) || py < $signed(bb.ymin));
  end

  genvar g;
  generate
    for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
      logic we_g, act_g, wrap_g;
      assign we_g   = load_req && (32'(vertex_index) == g);
      assign act_g  = (32'(n_eff) > g);
      assign wrap_g = (32'(n_eff) == g + 1) || (g == MAX_VERTICES - 1);
      pip_cell #(
        .IS_FIRST (g == 0),
        .CW       (CW)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .we       (we_g),
        .wx       (coord_x),
        .wy       (coord_y),
        .active   (act_g),
        .nbr_x    (wrap_g ? own_x[0] : own_x[(g + 1) % MAX_VERTICES]),
        .nbr_y    (wrap_g ? own_y[0] : own_y[(g + 1) % MAX_VERTICES]),
        .bbox_in  (bbox[(g + MAX_VERTICES - 1) % MAX_VERTICES]),
        .calc     (calc),
        .cnt_in   ((g == 0) ? '0 : cnt[(g + MAX_VERTICES - 1) % MAX_VERTICES]),
        .own_x    (own_x[g]),
        .own_y    (own_y[g]),
        .bbox_out (bbox[g]),
        .cnt_out  (cnt[g])
      );
    end
  endgenerate

  // result register
  logic [4:0] cnt5;
  assign cnt5 = 5'(cnt[MAX_VERTICES-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      in_box         <= box_ok;
      inside_res     <= box_ok && cnt5[0];
      crossing_count <= !box_ok ? 3'd0 : (cnt5 > 5'd7 ? 3'd7 : cnt5[2:0]);
    end
  end

endmodule

// ===== rtl/pip_checker.sv =====
// port-level checks for the point-in-polygon test, bound to the top level
module pip_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       inside_res,
  input logic       in_box,
  input logic [2:0] crossing_count
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_box |-> !inside_res && crossing_count == 3'd0)
    else $error("outside point has crossings");

  a_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && crossing_count != 3'd7 |-> inside_res == crossing_count[0])
    else $error("inside flag disagrees with count parity");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode |=> !in_ready)
    else $error("new request taken while a query runs");

endmodule

bind polygon_point_inside_test_core pip_checker u_pip_checker (.*);

// ===== tb/pip_checker.sv =====
// checker for the point-in-polygon core: predicts each query result and compares
module pip_scoreboard
  import pip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      mode,
  input  logic        [1:0]         vertex_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      inside_res,
  input  logic                      in_box,
  input  logic        [2:0]         crossing_count,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic        [CFG_W-1:0]   cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        result_count,
  output int                        inside_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = MAX_VERTICES_DEF;

  typedef struct {
    logic       is_in;
    logic       boxed;
    logic [2:0] crossings;
  } verdict_t;

  verdict_t verdict_q[$];
  logic [NODE_W-1:0] node_cnt;
  logic [EPS_W-1:0]  eps_reg;
  longint vx_store[NV];
  longint vy_store[NV];

  function automatic verdict_t classify_point(longint px, longint py);
    verdict_t r;
    int n;
    int cnt;
    int j;
    longint xmin, xmax, ymin, ymax, rx, vx, xi, yi, uix, uiy, num, den, eps;
    logic signed [127:0] ta, tb, tc, td, t, lim;
    bit mu_ok;
    r = '{1'b0, 1'b0, 3'd0};
    cnt = 0;
    n = node_cnt;
    if (n < 3) n = 3;
    if (n > NV) n = NV;
    xmin = vx_store[0]; xmax = vx_store[0];
    ymin = vy_store[0]; ymax = vy_store[0];
    for (int i = 1; i < n; i++) begin
      if (vx_store[i] > xmax) xmax = vx_store[i];
      if (vx_store[i] < xmin) xmin = vx_store[i];
      if (vy_store[i] > ymax) ymax = vy_store[i];
      if (vy_store[i] < ymin) ymin = vy_store[i];
    end
    if (px > xmax || px < xmin || py > ymax || py < ymin) return r;
    rx = xmin - 2 * (xmin < 0 ? -xmin : xmin);
    vx = px - rx;
    eps = eps_reg;
    if (vx > 0) begin
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        xi = vx_store[i];
        yi = vy_store[i];
        uix = vx_store[j] - xi;
        uiy = vy_store[j] - yi;
        num = py - yi;
        den = uiy;
        if (uiy != 0) begin
          if (den < 0) begin
            den = -den;
            num = -num;
          end
          mu_ok = (num < den) && (num >= 0 || num * 65536 + eps * den > 0);
          if (mu_ok) begin
            ta = xi - rx; tb = den; tc = num; td = uix;
            t = ta * tb + tc * td;
            tc = vx;
            lim = tb * tc;
            if (t > 0 && t < lim) cnt++;
          end
        end
      end
    end
    r.is_in = cnt[0];
    r.boxed = 1'b1;
    r.crossings = (cnt > 7) ? 3'd7 : 3'(cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t got, want;
    int errs;
    errs = 0;
    if (rst) begin
      node_cnt <= NODE_COUNT_RST;
      eps_reg <= EDGE_EPS_RST;
      for (int i = 0; i < NV; i++) begin
        vx_store[i] = 0;
        vy_store[i] = 0;
      end
      verdict_q.delete();
      fail_count <= 0;
      result_count <= 0;
      inside_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NODE_COUNT) node_cnt <= cfg_data[NODE_W-1:0];
        else eps_reg <= cfg_data[EPS_W-1:0];
      end
      if (out_valid && out_ready) begin
        got = '{inside_res, in_box, crossing_count};
        result_count <= result_count + 1;
        if (verdict_q.size() == 0) begin
          $error("result with no query outstanding");
          errs++;
        end else begin
          want = verdict_q.pop_front();
          if (want.is_in) inside_count <= inside_count + 1;
          if (got.is_in !== want.is_in) begin
            $error("inside_res expected %0d got %0d", want.is_in, got.is_in);
            errs++;
          end
          if (got.boxed !== want.boxed) begin
            $error("in_box expected %0d got %0d", want.boxed, got.boxed);
            errs++;
          end
          if (got.crossings !== want.crossings) begin
            $error("crossing_count expected %0d got %0d", want.crossings, got.crossings);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (in_valid && in_ready) begin
        if (mode == MODE_LOAD) begin
          vx_store[vertex_index] = longint'(coord_x);
          vy_store[vertex_index] = longint'(coord_y);
        end else begin
          verdict_q.push_back(classify_point(longint'(coord_x), longint'(coord_y)));
        end
      end
    end
    pending = verdict_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
// top of the point-in-polygon testbench: stimulus, reset, timeout and verdict
module testbench;
  import pip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * MAX_VERTICES_DEF + 6;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = MODE_LOAD;
  logic [1:0] vertex_index = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic inside_res, in_box;
  logic [2:0] crossing_count;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_NODE_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  int fail_count, pending, result_count, inside_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int request_count = 0;
  int cycles = 0;
  longint box_lo_x, box_hi_x, box_lo_y, box_hi_y;

  always #1 clk = ~clk;

  polygon_point_inside_test_core uut (.*);

  pip_scoreboard chk (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic m, logic [1:0] idx, logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    vertex_index <= idx;
    coord_x <= x;
    coord_y <= y;
    do @(posedge clk); while (!in_ready);
    request_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic longint rand_coord(int kind);
    case (kind)
      0: return longint'(signed'($urandom_range(255))) - 128;
      1: return longint'($urandom_range(2 * (1 << 20))) - (1 << 20);
      default: return longint'(signed'(32'($urandom)));
    endcase
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    longint span;
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % 64'(span));
  endfunction

  task automatic load_polygon();
    int kind;
    int order[4];
    longint x, y;
    kind = $urandom_range(9) < 2 ? 2 : $urandom_range(1);
    order = '{0, 1, 2, 3};
    order.shuffle();
    box_lo_x = 64'sh7fffffff; box_hi_x = -64'sh80000000;
    box_lo_y = 64'sh7fffffff; box_hi_y = -64'sh80000000;
    foreach (order[k]) begin
      x = rand_coord(kind);
      y = ($urandom_range(7) == 0 && k > 0) ? longint'(coord_y) : rand_coord(kind);
      if (x < box_lo_x) box_lo_x = x;
      if (x > box_hi_x) box_hi_x = x;
      if (y < box_lo_y) box_lo_y = y;
      if (y > box_hi_y) box_hi_y = y;
      send(MODE_LOAD, 2'(order[k]), 32'(x), 32'(y));
    end
  endtask

  initial begin
    logic [2:0] node_vals[8];
    logic [15:0] eps_vals[8];
    int nq;
    node_vals = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6};
    eps_vals = '{16'd0, 16'd65535, 16'd1, 16'd300,
                 16'd65535, 16'd0, 16'd4096, 16'd20};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // square with horizontal edges
    send(MODE_LOAD, 2'd0, -32'sd10 <<< 16, -32'sd10 <<< 16);
    send(MODE_LOAD, 2'd1, 32'sd10 <<< 16, -32'sd10 <<< 16);
    send(MODE_LOAD, 2'd2, 32'sd10 <<< 16, 32'sd10 <<< 16);
    send(MODE_LOAD, 2'd3, -32'sd10 <<< 16, 32'sd10 <<< 16);
    send(MODE_QUERY, 2'd0, 32'sd0, 32'sd0);
    send(MODE_QUERY, 2'd3, 32'sd20 <<< 16, 32'sd0);
    send(MODE_QUERY, 2'd0, 32'sd10 <<< 16, 32'sd10 <<< 16);
    send(MODE_QUERY, 2'd0, -32'sd10 <<< 16, 32'sd0);
    send(MODE_QUERY, 2'd0, 32'sd0, -32'sd10 <<< 16);
    // full-range corners
    send(MODE_LOAD, 2'd0, 32'h80000000, 32'h80000000);
    send(MODE_LOAD, 2'd1, 32'h7fffffff, 32'h80000000);
    send(MODE_LOAD, 2'd2, 32'h7fffffff, 32'h7fffffff);
    send(MODE_LOAD, 2'd3, 32'h80000000, 32'h7fffffff);
    send(MODE_QUERY, 2'd1, 32'd0, 32'd0);
    send(MODE_QUERY, 2'd2, 32'h80000000, 32'h80000000);
    send(MODE_QUERY, 2'd0, 32'h7fffffff, 32'h7fffffff);
    send(MODE_QUERY, 2'd0, 32'h7ffffffe, 32'h00000001);
    // zero ray length: xmin at zero, point on x = 0
    send(MODE_LOAD, 2'd0, 32'd0, 32'd0);
    send(MODE_LOAD, 2'd1, 32'sd4 <<< 16, 32'd0);
    send(MODE_LOAD, 2'd2, 32'sd4 <<< 16, 32'sd4 <<< 16);
    send(MODE_LOAD, 2'd3, 32'd0, 32'sd4 <<< 16);
    send(MODE_QUERY, 2'd0, 32'd0, 32'sd2 <<< 16);
    send(MODE_QUERY, 2'd0, 32'sd1, 32'sd2 <<< 16);

    for (int blk = 0; blk < 8; blk++) begin
      settle();
      write_reg(REG_NODE_COUNT, CFG_W'(node_vals[blk]));
      write_reg(REG_EDGE_EPSILON, blk == 7 ? CFG_W'($urandom) : eps_vals[blk]);
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      nq = request_count + 250;
      while (request_count < nq) begin
        if ($urandom_range(9) == 0) begin
          send(logic'($urandom_range(1)), 2'($urandom), 32'($urandom), 32'($urandom));
        end else begin
          load_polygon();
          repeat ($urandom_range(8, 3)) begin
            if ($urandom_range(9) < 8)
              send(MODE_QUERY, 2'($urandom),
                   32'(rand_between(box_lo_x, box_hi_x)),
                   32'(rand_between(box_lo_y, box_hi_y)));
            else
              send(MODE_QUERY, 2'($urandom), 32'($urandom), 32'($urandom));
          end
        end
      end
      if (blk == 3) begin
        idle_pct = 0;
        stall_pct = 0;
      end
    end

    settle();
    $display("sent %0d requests across 8 register settings and 4 idling modes", request_count);
    $display("checked %0d query results, %0d of them inside", result_count, inside_count);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pip_pkg.sv
rtl/pip_cell.sv
rtl/polygon_point_inside_test_core.sv
rtl/pip_checker.sv
tb/pip_checker.sv
tb/testbench.sv
